/* hdl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants
// Widths, register indexes and structs for the wildcard byte pattern search.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int OFFSET_BITS = 32;

	localparam int WIN_DEPTH   = PATTERN_MAX - 1;
	localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CNT_W       = ($clog2(PATTERN_MAX + 1) > 5) ? $clog2(PATTERN_MAX + 1) : 5;

	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int WILD_W      = 16;
	localparam int LEN_W       = 5;
	localparam int MATCH_OFF_W = 32;
	localparam int CFG_BYTES   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILD   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN    = 2'd3;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

	typedef struct packed {
		logic shift;
		logic clear;
	} wbps_cell_ctl_t;

	typedef struct packed {
		logic              active;
		logic              wild;
		logic [BYTE_W-1:0] pat;
	} wbps_cell_cmp_t;

	typedef struct packed {
		logic                   found;
		logic [MATCH_OFF_W-1:0] match_offset;
	} wbps_res_t;

endpackage

`default_nettype wire

/* hdl/wbps_if.sv */
// ----------------------------------------------------------------------------
// wbps_if: stream channels
// Input byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_in_if;
	logic                       valid;
	logic                       ready;
	logic [wbps_pkg::BYTE_W-1:0] data_byte;
	logic                       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
	logic                            valid;
	logic                            ready;
	logic                            found;
	logic [wbps_pkg::MATCH_OFF_W-1:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

/* hdl/wbps_cell.sv */
// ----------------------------------------------------------------------------
// wbps_cell: one window cell
// Holds one past byte, hands it to the next cell and does a masked compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire wbps_pkg::wbps_cell_ctl_t    ctl,
	input  wire logic [wbps_pkg::BYTE_W-1:0] byte_in,
	input  wire wbps_pkg::wbps_cell_cmp_t    cmp,
	output logic [wbps_pkg::BYTE_W-1:0]      byte_out,
	output logic                             ok
);

	logic [wbps_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign ok       = !cmp.active || cmp.wild || (byte_q == cmp.pat);

endmodule

`default_nettype wire

/* hdl/wbps_outq.sv */
// ----------------------------------------------------------------------------
// wbps_outq: result queue
// Two-entry queue between the compare logic and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_outq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire wbps_pkg::wbps_res_t push_data,
	output logic                    full,
	wbps_out_if.source              out_ch
);

	wbps_pkg::wbps_res_t mem_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                pop;

	assign pop  = out_ch.valid && out_ch.ready;
	assign full = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign out_ch.valid        = (count_q != 2'd0);
	assign out_ch.found        = mem_q[rd_ptr_q].found;
	assign out_ch.match_offset = mem_q[rd_ptr_q].match_offset;

endmodule

`default_nettype wire

/* hdl/wildcard_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search: first-match search with wildcards
// Shift window of byte cells, masked compare, one result per region.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  in_ch     in   data_byte, last_byte
//  out_ch    out  found, match_offset
//  cfg_*     in   cfg_index, cfg_data (write only)
//
//  One byte per cycle unless stalled; a match is decided as the byte is taken.
//  A result shows on out_ch the cycle after its byte when none is queued ahead.
//  Two results can wait; in_ch stalls only while both result slots are held.
//  Reset clears window, position and report flag; region end does the same.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_search (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wbps_pkg::CFG_W-1:0]     cfg_data,
	wbps_in_if.sink                             in_ch,
	wbps_out_if.source                          out_ch
);

	localparam int PM   = wbps_pkg::PATTERN_MAX;
	localparam int WIN  = wbps_pkg::WIN_DEPTH;
	localparam int CW   = wbps_pkg::CNT_W;
	localparam int IW   = wbps_pkg::IDX_W;
	localparam int OB   = wbps_pkg::OFFSET_BITS;
	localparam int BW   = wbps_pkg::BYTE_W;

	logic [wbps_pkg::CFG_W-1:0]  pat_lo_q;
	logic [wbps_pkg::CFG_W-1:0]  pat_hi_q;
	logic [wbps_pkg::WILD_W-1:0] wild_q;
	logic [wbps_pkg::LEN_W-1:0]  len_q;

	logic [OB-1:0]               pos_q;
	logic                        reported_q;

	logic [BW-1:0]               pat_arr [PM];
	logic [PM-1:0]               wild_arr;
	logic [CW-1:0]               eff_len;
	logic [CW-1:0]               eff_m1;
	logic                        accept;
	logic                        full;
	logic                        cur_ok;
	logic                        pos_ok;
	logic                        hit;
	logic                        emit;
	logic [OB-1:0]               offset;
	wbps_pkg::wbps_res_t         res;
	wbps_pkg::wbps_cell_ctl_t    ctl;
	logic [BW-1:0]               chain [WIN+1];
	logic [WIN:0]                cell_ok;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			len_q    <= wbps_pkg::LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wbps_pkg::REG_PAT_LO: pat_lo_q <= cfg_data;
				wbps_pkg::REG_PAT_HI: pat_hi_q <= cfg_data;
				wbps_pkg::REG_WILD:   wild_q   <= cfg_data[wbps_pkg::WILD_W-1:0];
				wbps_pkg::REG_LEN:    len_q    <= cfg_data[wbps_pkg::LEN_W-1:0];
				default:              len_q    <= len_q;
			endcase
		end
	end

	for (genvar k = 0; k < PM; k++) begin : g_pat
		if (k < 8) begin : g_lo
			assign pat_arr[k]  = pat_lo_q[BW*k +: BW];
			assign wild_arr[k] = wild_q[k];
		end else if (k < wbps_pkg::CFG_BYTES) begin : g_hi
			assign pat_arr[k]  = pat_hi_q[BW*(k-8) +: BW];
			assign wild_arr[k] = wild_q[k];
		end else begin : g_none
			assign pat_arr[k]  = '0;
			assign wild_arr[k] = 1'b0;
		end
	end

	assign eff_len = (CW'(len_q) > CW'(PM)) ? CW'(PM) : CW'(len_q);
	assign eff_m1  = eff_len - CW'(1);

	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !full;
	assign ctl.shift   = accept && !in_ch.last_byte;
	assign ctl.clear   = accept && in_ch.last_byte;

	// window chain: cell d holds the byte d steps back
	assign chain[0]   = in_ch.data_byte;
	assign cell_ok[0] = 1'b1;

	for (genvar d = 1; d <= WIN; d++) begin : g_cell
		logic [CW-1:0]             kd;
		wbps_pkg::wbps_cell_cmp_t  cmp;

		assign kd         = eff_m1 - CW'(d);
		assign cmp.active = CW'(d) < eff_len;
		assign cmp.wild   = wild_arr[kd[IW-1:0]];
		assign cmp.pat    = pat_arr[kd[IW-1:0]];

		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.byte_in  (chain[d-1]),
			.cmp      (cmp),
			.byte_out (chain[d]),
			.ok       (cell_ok[d])
		);
	end

	assign cur_ok = wild_arr[eff_m1[IW-1:0]] || (in_ch.data_byte == pat_arr[eff_m1[IW-1:0]]);
	assign pos_ok = (pos_q >= OB'(eff_m1));

	always_comb begin
		if (eff_len == '0) begin
			hit    = 1'b1;
			offset = pos_q;
		end else begin
			hit    = pos_ok && cur_ok && (&cell_ok);
			offset = pos_q - OB'(eff_m1);
		end
	end

	assign emit             = accept && !reported_q && (hit || in_ch.last_byte);
	assign res.found        = hit;
	assign res.match_offset = hit ? wbps_pkg::MATCH_OFF_W'(offset) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + OB'(1);
				end
				if (!reported_q && hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	wbps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res),
		.full      (full),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

/* verif/wildcard_byte_pattern_search_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_test: self-checking regression
// Streams byte regions through the search block and keeps a software copy of
// its window, position and report flag to predict each found / not-found
// beat. Results are compared in order, field by field. The sender works in
// bursts with gaps and the result side stalls in changing patterns. Patterns,
// wildcard masks and lengths change between phases, extremes included.
// ----------------------------------------------------------------------------

module wildcard_byte_pattern_search_test;

	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_ITEMS = 800;
	localparam int REPORT_MAX   = 10;
	localparam int TAIL_CYCLES  = 20;
	localparam longint unsigned POS_LIMIT = (64'd1 << wbps_pkg::OFFSET_BITS) - 1;

	typedef logic [wbps_pkg::BYTE_W-1:0] region_t [$];
	typedef enum int {RX_FREE, RX_COIN, RX_CADENCE, RX_HOLD} rx_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wbps_pkg::CFG_W-1:0]     cfg_data;

	wbps_in_if  in_ch ();
	wbps_out_if out_ch ();

	wildcard_byte_pattern_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	logic [wbps_pkg::CFG_W-1:0]  pat_lo_q;
	logic [wbps_pkg::CFG_W-1:0]  pat_hi_q;
	logic [wbps_pkg::WILD_W-1:0] wild_q;
	logic [wbps_pkg::LEN_W-1:0]  len_q;
	logic [wbps_pkg::BYTE_W-1:0] window_q [wbps_pkg::WIN_DEPTH];
	longint unsigned             position_q;
	bit                          reported_q;

	wbps_pkg::wbps_res_t expected_results [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	int        items_sent = 0;

	rx_mode_t  rx_mode = RX_FREE;
	int        rx_left = 0;
	int        rx_phase = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("ERROR at %0t: %s", $time, msg);
	endfunction

	function automatic void add_expected(input wbps_pkg::wbps_res_t res);
		expected_results.insert(expected_results.size(), res);
	endfunction

	function automatic logic [wbps_pkg::BYTE_W-1:0] pattern_byte(input int k);
		if (k < 8)
			return pat_lo_q[8*k +: 8];
		return pat_hi_q[8*(k-8) +: 8];
	endfunction

	function automatic int active_length();
		return (int'(len_q) > wbps_pkg::PATTERN_MAX) ? wbps_pkg::PATTERN_MAX : int'(len_q);
	endfunction

	function automatic void clear_region();
		foreach (window_q[i])
			window_q[i] = '0;
		position_q = 0;
		reported_q = 1'b0;
	endfunction

	function automatic void scan_byte(input logic [wbps_pkg::BYTE_W-1:0] cur, input bit is_last);
		int                          len;
		bit                          hit;
		longint unsigned             offset;
		logic [wbps_pkg::BYTE_W-1:0] b;
		wbps_pkg::wbps_res_t         res;
		len = active_length();
		hit = 1'b0;
		offset = 0;
		if (!reported_q) begin
			if (len == 0) begin
				hit = 1'b1;
				offset = position_q;
			end else if (position_q >= longint'(len - 1)) begin
				hit = 1'b1;
				for (int k = 0; k < len; k++) begin
					b = (k == len - 1) ? cur : window_q[len - 2 - k];
					if (!wild_q[k] && b != pattern_byte(k))
						hit = 1'b0;
				end
				offset = position_q - longint'(len - 1);
			end
			if (hit) begin
				res.found = 1'b1;
				res.match_offset = offset[wbps_pkg::MATCH_OFF_W-1:0];
				add_expected(res);
				reported_q = 1'b1;
			end else if (is_last) begin
				res.found = 1'b0;
				res.match_offset = '0;
				add_expected(res);
			end
		end
		if (is_last) begin
			clear_region();
			return;
		end
		for (int i = wbps_pkg::WIN_DEPTH - 1; i > 0; i--)
			window_q[i] = window_q[i-1];
		window_q[0] = cur;
		if (position_q < POS_LIMIT)
			position_q++;
	endfunction

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 150);
			rx_phase = 0;
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_FREE:    out_ch.ready <= 1'b1;
			RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
			RX_CADENCE: out_ch.ready <= ((rx_phase % 7) < 4);
			RX_HOLD:    out_ch.ready <= ((rx_phase % 32) >= 22);
			default:    out_ch.ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		wbps_pkg::wbps_res_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("unexpected result: found %0b offset %0d",
					out_ch.found, out_ch.match_offset));
			end else begin
				want = expected_results.pop_front();
				if (out_ch.found !== want.found || out_ch.match_offset !== want.match_offset)
					note_failure($sformatf(
						"expected found %0b offset %0d, got found %0b offset %0d",
						want.found, want.match_offset, out_ch.found, out_ch.match_offset));
			end
		end
	end

	task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] value, input bit is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= value;
		in_ch.last_byte <= is_last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		scan_byte(value, is_last);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_region(input region_t region);
		foreach (region[i])
			send_byte(region[i], i == region.size() - 1);
	endtask

	// hold input until every result is in, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
			input logic [wbps_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			wbps_pkg::REG_PAT_LO: pat_lo_q = value;
			wbps_pkg::REG_PAT_HI: pat_hi_q = value;
			wbps_pkg::REG_WILD:   wild_q = value[wbps_pkg::WILD_W-1:0];
			wbps_pkg::REG_LEN:    len_q = value[wbps_pkg::LEN_W-1:0];
			default:              ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_pattern(input logic [wbps_pkg::CFG_W-1:0] lo,
			input logic [wbps_pkg::CFG_W-1:0] hi,
			input logic [wbps_pkg::WILD_W-1:0] wild, input logic [wbps_pkg::LEN_W-1:0] len);
		logic [wbps_pkg::CFG_W-1:0] wild_word;
		logic [wbps_pkg::CFG_W-1:0] len_word;
		wild_word = {$urandom, $urandom};
		wild_word[wbps_pkg::WILD_W-1:0] = wild;
		len_word = {$urandom, $urandom};
		len_word[wbps_pkg::LEN_W-1:0] = len;
		wait_idle();
		write_reg(wbps_pkg::REG_PAT_LO, lo);
		write_reg(wbps_pkg::REG_PAT_HI, hi);
		write_reg(wbps_pkg::REG_WILD, wild_word);
		write_reg(wbps_pkg::REG_LEN, len_word);
	endtask

	task automatic test_reset_defaults();
		send_region('{8'hFF, 8'h00});
	endtask

	task automatic test_wildcard_match();
		load_pattern(64'h0000_0000_7E00_C3A5, 64'h0, 16'h0004, 5'd4);
		send_region('{8'h11, 8'hA5, 8'hC3, 8'h00, 8'h7E, 8'h33});
	endtask

	task automatic test_short_regions();
		send_region('{8'hA5, 8'hC3});
		send_region('{8'h00, 8'h7E});
	endtask

	task automatic test_match_on_last();
		send_region('{8'hA5, 8'hC3, 8'hFF, 8'h7E});
	endtask

	task automatic test_length_extremes();
		load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd0);
		send_region('{8'h5A, 8'hC3});
		load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd31);
		send_region('{8'h5A, 8'hC3});
	endtask

	function automatic logic [wbps_pkg::CFG_W-1:0] pick_pattern_word();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [wbps_pkg::WILD_W-1:0] pick_wild_mask();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return wbps_pkg::WILD_W'($urandom & $urandom & $urandom);
			default: return wbps_pkg::WILD_W'($urandom);
		endcase
	endfunction

	function automatic logic [wbps_pkg::LEN_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0:       return 5'd0;
			1:       return 5'($urandom_range(wbps_pkg::PATTERN_MAX + 1, 31));
			2:       return 5'(wbps_pkg::PATTERN_MAX);
			3, 4:    return 5'($urandom_range(5, wbps_pkg::PATTERN_MAX));
			default: return 5'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic region_t build_region();
		region_t region;
		int      len;
		int      rlen;
		int      at;
		int      k;
		bit      from_pattern;
		len = active_length();
		rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
		if (len > 8 && $urandom_range(0, 1) == 1)
			rlen = $urandom_range(len, len + 12);
		from_pattern = ($urandom_range(0, 1) == 1);
		for (int i = 0; i < rlen; i++)
			region.insert(region.size(), from_pattern
				? pattern_byte($urandom_range(0, wbps_pkg::PATTERN_MAX - 1))
				: wbps_pkg::BYTE_W'($urandom));
		if (len > 0 && $urandom_range(0, 9) < 7) begin
			at = $urandom_range(0, rlen - 1);
			for (int j = 0; j < len; j++)
				if (at + j < rlen)
					region[at + j] = wild_q[j] ? wbps_pkg::BYTE_W'($urandom) : pattern_byte(j);
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, len - 1);
				if (at + k < rlen)
					region[at + k] ^= wbps_pkg::BYTE_W'(1 << $urandom_range(0, wbps_pkg::BYTE_W - 1));
			end
		end
		return region;
	endfunction

	task automatic test_random_regions();
		int stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			load_pattern(pick_pattern_word(), pick_pattern_word(), pick_wild_mask(),
				pick_length());
			repeat ($urandom_range(3, 8))
				send_region(build_region());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = wbps_pkg::REG_PAT_LO;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		pat_lo_q = '0;
		pat_hi_q = '0;
		wild_q = '0;
		len_q = wbps_pkg::LEN_RESET;
		clear_region();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_wildcard_match();
		test_short_regions();
		test_match_on_last();
		test_length_extremes();
		test_random_regions();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			note_failure($sformatf("%0d expected results never arrived",
				expected_results.size()));
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
